@@ rtl/tlcc_pkg.sv @@
// Package for the traffic light countdown controller.
// Holds lamp codes, phase and register index constants and the display bundle.
// No dependencies.
package tlcc_pkg;

  localparam int CountW = 7;
  localparam int AmberW = 4;
  localparam int SweepW = 6;

  // Phase codes, also used for the manual selection
  localparam logic [1:0] PH_WEST_GREEN  = 2'd0;
  localparam logic [1:0] PH_WEST_AMBER  = 2'd1;
  localparam logic [1:0] PH_SOUTH_GREEN = 2'd2;
  localparam logic [1:0] PH_SOUTH_AMBER = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WEST_START  = 2'd0;
  localparam logic [1:0] CFG_SOUTH_START = 2'd1;
  localparam logic [1:0] CFG_AMBER       = 2'd2;
  localparam logic [1:0] CFG_SWEEPS      = 2'd3;

  localparam logic [5:0] LAMP_WEST_GREEN  = 6'b100001;
  localparam logic [5:0] LAMP_WEST_AMBER  = 6'b010001;
  localparam logic [5:0] LAMP_SOUTH_GREEN = 6'b001100;
  localparam logic [5:0] LAMP_SOUTH_AMBER = 6'b001010;

  localparam logic [3:0] DIGITS_OFF = 4'hF;

  typedef struct packed {
    logic              blank;   // manual green: digits off
    logic [1:0]        phase;   // phase or manual selection on show
    logic [CountW-1:0] count;
    logic [AmberW-1:0] amber;
    logic [1:0]        slot;
  } disp_t;

  function automatic logic [5:0] lamp_of(input logic [1:0] ph);
    logic [5:0] l;
    unique case (ph)
      PH_WEST_GREEN:  l = LAMP_WEST_GREEN;
      PH_WEST_AMBER:  l = LAMP_WEST_AMBER;
      PH_SOUTH_GREEN: l = LAMP_SOUTH_GREEN;
      default:        l = LAMP_SOUTH_AMBER;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/tlcc_display.sv @@
// Display decode for the traffic light countdown controller.
// Turns phase, count and slot into lamp bits and one multiplexed digit.
// Depends on tlcc_pkg.
module tlcc_display (
  input  tlcc_pkg::disp_t disp_i,
  output logic [5:0]      lamp_o,
  output logic [3:0]      digit_enable_n_o,
  output logic [3:0]      digit_value_o
);
  import tlcc_pkg::*;

  logic [CountW-1:0] cnt_clip;
  logic [CountW:0]   diff;
  logic [CountW-1:0] other;
  logic [CountW-1:0] west;
  logic [CountW-1:0] south;
  logic [CountW-1:0] shown;
  logic [13:0]       prod;
  logic [3:0]        tens;
  logic [CountW-1:0] tens_x10;
  logic [CountW-1:0] ones;

  always_comb begin
    cnt_clip = (disp_i.count > 7'd99) ? 7'd99 : disp_i.count;
    diff     = {1'b0, disp_i.count} - {{(CountW + 1 - AmberW){1'b0}}, disp_i.amber};
    if (diff[CountW]) begin
      other = '0;
    end else if (diff[CountW-1:0] > 7'd99) begin
      other = 7'd99;
    end else begin
      other = diff[CountW-1:0];
    end
    west  = cnt_clip;
    south = cnt_clip;
    // Green: the side without green counts down to its own green
    if (disp_i.phase == PH_WEST_GREEN) begin
      south = other;
    end else if (disp_i.phase == PH_SOUTH_GREEN) begin
      west = other;
    end
    shown = disp_i.slot[1] ? south : west;
    // x/10 as (x*103)>>10, exact for 0..99
    prod     = 14'(shown) * 14'd103;
    tens     = prod[13:10];
    tens_x10 = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
    ones     = shown - tens_x10;
  end

  assign lamp_o = lamp_of(disp_i.phase);

  always_comb begin
    if (disp_i.blank) begin
      digit_enable_n_o = DIGITS_OFF;
      digit_value_o    = '0;
    end else begin
      digit_enable_n_o = ~(4'b0001 << disp_i.slot);
      digit_value_o    = disp_i.slot[0] ? ones[3:0] : tens;
    end
  end

endmodule

@@ rtl/traffic_light_countdown_controller_unit.sv @@
// Two-way traffic light controller with a multiplexed four-digit countdown.
// Depends on tlcc_pkg and tlcc_display.
//
// Input channel (in_valid/in_ready): one item per multiplex tick or button
// press, carrying the auto/manual switch level. Each item gives exactly one
// result item on the output channel: lamp bits, active-low digit enables and
// the digit value for the current display slot.
// The state update and display decode for an item are combinational and sit
// between the input handshake and the result register. One item per cycle is
// sustained while out_ready is high; the result register is the only buffer,
// so in_ready follows "result register empty or being taken this cycle".
// When the receiver stalls, the result holds and in_ready drops until it is
// taken; no item is lost or repeated.
// Reset (rst_n, synchronous, active low) gives west green, count at the west
// green start, slot and sweep counter at zero, automatic mode, and restores
// the register defaults 15, 23, 3 and 25.
// Configuration (cfg_we/cfg_index/cfg_wdata) is written when cfg_we is high;
// the start counts take effect at the next phase entry, amber and sweeps at once.
module traffic_light_countdown_controller_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic       in_manual_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_lamp_pattern,
  output logic [3:0] out_digit_enable_n,
  output logic [3:0] out_digit_value,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);
  import tlcc_pkg::*;

  logic [CountW-1:0] west_start_r, south_start_r;
  logic [AmberW-1:0] amber_r;
  logic [SweepW-1:0] sweeps_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [SweepW-1:0] sweep_r, sweep_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic              mar_r, mar_nxt;   // manual amber running
  logic              prev_mode_r;

  logic              out_valid_r;
  logic [5:0]        lamp_r;
  logic [3:0]        en_n_r, value_r;

  logic              accept;
  logic              manual;
  logic [SweepW-1:0] limit;
  logic [SweepW-1:0] sweep_inc;
  disp_t             disp;
  logic [5:0]        lamp_c;
  logic [3:0]        en_n_c, value_c;

  assign manual   = in_manual_mode;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign limit    = (sweeps_r == '0) ? SweepW'(1) : sweeps_r;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sweep_nxt = sweep_r;
    slot_nxt  = slot_r;
    sel_nxt   = sel_r;
    mar_nxt   = mar_r;
    sweep_inc = '0;

    // Mode switch
    if (manual != prev_mode_r) begin
      mar_nxt = 1'b0;
      if (!manual) begin
        phase_nxt = PH_WEST_GREEN;
        count_nxt = west_start_r;
      end
      slot_nxt  = '0;
      sweep_nxt = '0;
    end
    if (manual && !mar_nxt && sel_nxt[0]) begin
      mar_nxt   = 1'b1;
      count_nxt = CountW'(amber_r);
      sweep_nxt = '0;
    end

    if (in_operation && !(manual && mar_nxt)) begin
      sel_nxt = sel_nxt + 2'd1;
      if (manual && sel_nxt[0]) begin
        mar_nxt   = 1'b1;
        count_nxt = CountW'(amber_r);
        sweep_nxt = '0;
      end
    end

    // Display uses the state before the slot advances
    disp.blank = manual && !mar_nxt;
    disp.phase = manual ? sel_nxt : phase_nxt;
    disp.count = count_nxt;
    disp.amber = amber_r;
    disp.slot  = slot_nxt;

    if (!in_operation) begin
      slot_nxt = slot_nxt + 2'd1;
      if (slot_nxt == 2'd0 && (!manual || mar_nxt)) begin
        sweep_inc = sweep_nxt + SweepW'(1);
        sweep_nxt = sweep_inc;
        if (sweep_inc >= limit) begin
          sweep_nxt = '0;
          if (manual) begin
            if (count_nxt <= CountW'(1)) begin
              mar_nxt = 1'b0;
              sel_nxt = sel_nxt + 2'd1;
            end else begin
              count_nxt = count_nxt - CountW'(1);
            end
          end else if (!phase_nxt[0]) begin
            if (count_nxt <= CountW'(amber_r) + CountW'(1)) begin
              phase_nxt = phase_nxt + 2'd1;
              count_nxt = CountW'(amber_r);
            end else begin
              count_nxt = count_nxt - CountW'(1);
            end
          end else begin
            if (count_nxt <= CountW'(1)) begin
              phase_nxt = phase_nxt + 2'd1;
              count_nxt = (phase_nxt == PH_WEST_GREEN) ? west_start_r : south_start_r;
            end else begin
              count_nxt = count_nxt - CountW'(1);
            end
          end
        end
      end
    end
  end

  tlcc_display u_display (
    .disp_i           (disp),
    .lamp_o           (lamp_c),
    .digit_enable_n_o (en_n_c),
    .digit_value_o    (value_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_start_r  <= 7'd15;
      south_start_r <= 7'd23;
      amber_r       <= 4'd3;
      sweeps_r      <= 6'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEST_START:  west_start_r  <= cfg_wdata;
        CFG_SOUTH_START: south_start_r <= cfg_wdata;
        CFG_AMBER:       amber_r       <= cfg_wdata[AmberW-1:0];
        CFG_SWEEPS:      sweeps_r      <= cfg_wdata[SweepW-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WEST_GREEN;
      count_r     <= 7'd15;
      sweep_r     <= '0;
      slot_r      <= '0;
      sel_r       <= PH_WEST_GREEN;
      mar_r       <= 1'b0;
      prev_mode_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      sweep_r     <= sweep_nxt;
      slot_r      <= slot_nxt;
      sel_r       <= sel_nxt;
      mar_r       <= mar_nxt;
      prev_mode_r <= manual;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lamp_r  <= lamp_c;
      en_n_r  <= en_n_c;
      value_r <= value_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lamp_pattern   = lamp_r;
  assign out_digit_enable_n = en_n_r;
  assign out_digit_value    = value_r;

endmodule

@@ rtl/tlcc_checker.sv @@
// Port-level checks for the traffic light countdown controller.
// Bound to traffic_light_countdown_controller_unit; depends on tlcc_pkg.
module tlcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_lamp_pattern,
  input logic [3:0] out_digit_enable_n,
  input logic [3:0] out_digit_value
);
  import tlcc_pkg::*;

  // Every accepted item shows a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lamp_pattern)
      && $stable(out_digit_enable_n) && $stable(out_digit_value))
    else $error("stalled result changed");

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(~out_digit_enable_n))
    else $error("more than one digit enabled");

  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_enable_n == DIGITS_OFF |-> out_digit_value == 4'd0)
    else $error("blank display carries a digit");

  a_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_value <= 4'd9 && (out_lamp_pattern == LAMP_WEST_GREEN
      || out_lamp_pattern == LAMP_WEST_AMBER || out_lamp_pattern == LAMP_SOUTH_GREEN
      || out_lamp_pattern == LAMP_SOUTH_AMBER))
    else $error("digit not decimal or lamp code unknown");

endmodule

bind traffic_light_countdown_controller_unit tlcc_checker u_tlcc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_lamp_pattern   (out_lamp_pattern),
  .out_digit_enable_n (out_digit_enable_n),
  .out_digit_value    (out_digit_value)
);
